// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b on the same edge
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/tsct_pkg.sv =====
// package with formats, constants and coefficient table of the sine, cosine and tangent block
`default_nettype none
package tsct_pkg;
    localparam int SERIES_TERMS = 10;
    localparam int FRAC_BITS    = 40;
    localparam int VAL_W        = 52;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int OUT_W        = 48;
    localparam int QUO_W        = 64;
    localparam int DIV_STEPS    = 128;
    localparam int DIV_PER_STG  = 4;
    localparam int DIV_STAGES   = DIV_STEPS / DIV_PER_STG;

    localparam logic signed [VAL_W-1:0] PI_Q40     = 52'sh3243F6A8886;
    localparam logic signed [VAL_W-1:0] TWO_PI_Q40 = 52'sh6487ED5110B;
    localparam logic [VAL_W-1:0]        MAG_MAX    = 52'h3FFFFFFFFFFFF;
    localparam logic [OUT_W-1:0]        OUT_MAX    = 48'h7FFFFFFFFFFF;

    localparam logic [1:0] REQ_SIN = 2'd0;
    localparam logic [1:0] REQ_COS = 2'd1;
    localparam logic [1:0] REQ_TAN = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic [1:0] req;
        t_val       x;
        t_val       y;
        t_val       acc_s;
        t_val       acc_c;
    } t_poly;

    typedef struct packed {
        logic [1:0] req;
        t_val       s;
        t_val       c;
    } t_sc;

    function automatic t_val inv_fact(input int k);
        t_val r;
        r = '0;
        unique case (k)
            0:  r = 52'sd1099511627776;
            1:  r = 52'sd1099511627776;
            2:  r = 52'sd549755813888;
            3:  r = 52'sd183251937963;
            4:  r = 52'sd45812984491;
            5:  r = 52'sd9162596898;
            6:  r = 52'sd1527099483;
            7:  r = 52'sd218157069;
            8:  r = 52'sd27269634;
            9:  r = 52'sd3029959;
            10: r = 52'sd302996;
            11: r = 52'sd27545;
            12: r = 52'sd2295;
            13: r = 52'sd177;
            14: r = 52'sd13;
            15: r = 52'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_val coef(input int k);
        t_val c;
        c = inv_fact(k);
        return ((k / 2) % 2 == 1) ? -c : c;
    endfunction

    function automatic logic [VAL_W-1:0] mag(input t_val v);
        return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    // round a full magnitude product to 40 fractional bits and saturate
    function automatic t_val round_prod(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W-1:0] pr;
        logic [VAL_W-1:0]  m;
        pr = p + (PROD_W'(1) << (FRAC_BITS - 1));
        m  = (pr[PROD_W-1:FRAC_BITS] > PROD_W'(MAG_MAX)) ? MAG_MAX
                                                         : pr[FRAC_BITS+VAL_W-1:FRAC_BITS];
        return neg ? -t_val'(m) : t_val'(m);
    endfunction

    function automatic logic [OUT_W-1:0] to_q32(input t_val v);
        logic [VAL_W-1:0] m;
        logic [VAL_W-1:0] r;
        m = (mag(v) + VAL_W'(128)) >> 8;
        r = v[VAL_W-1] ? VAL_W'(-m) : m;
        return r[OUT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tsct_mul.sv =====
// pipelined signed q40 multiplier: magnitude product registered, then rounding registered
`default_nettype none
module tsct_mul
    import tsct_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_en,
    input  wire  t_val  i_a,
    input  wire  t_val  i_b,
    output t_val        o_p
);
    logic [PROD_W/2-1:0] r_lo_ll, r_lo_lh, r_lo_hl, r_lo_hh;
    logic                r_neg;
    logic [VAL_W-1:0]    n_ma, n_mb;
    logic [PROD_W-1:0]   n_prod;
    t_val                r_p;
    localparam int H = VAL_W / 2;

    assign n_ma = mag(i_a);
    assign n_mb = mag(i_b);
    assign n_prod = {r_lo_hh, {PROD_W/2{1'b0}}}
                  + (PROD_W'(r_lo_lh) << H) + (PROD_W'(r_lo_hl) << H) + PROD_W'(r_lo_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_ll <= (PROD_W/2)'(n_ma[H-1:0] * n_mb[H-1:0]);
            r_lo_lh <= (PROD_W/2)'(n_ma[H-1:0] * n_mb[VAL_W-1:H]);
            r_lo_hl <= (PROD_W/2)'(n_ma[VAL_W-1:H] * n_mb[H-1:0]);
            r_lo_hh <= (PROD_W/2)'(n_ma[VAL_W-1:H] * n_mb[VAL_W-1:H]);
            r_neg   <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
            r_p     <= round_prod(n_prod, r_neg);
        end
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== rtl/tsct_series.sv =====
// wrap and horner evaluation of sine and cosine, two multiplier stages per term
`default_nettype none
module tsct_series
    import tsct_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  wire  [1:0]  i_req,
    input  wire  [31:0] i_angle,
    output logic        o_valid,
    output t_sc         o_sc
);
    localparam int LAT = 2;
    localparam int NST = SERIES_TERMS;
    // stage 0 wrap, then y, then terms, then final x*acc
    logic [1:0] r_req0;
    t_val       r_x0;
    logic       r_v0;
    t_val       n_x;
    t_val       y_p;

    always_comb begin
        n_x = t_val'($signed(i_angle)) <<< 12;
        if (n_x > PI_Q40) n_x = n_x - TWO_PI_Q40;
        else if (n_x < -PI_Q40) n_x = n_x + TWO_PI_Q40;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_req0 <= i_req;
            r_x0   <= n_x;
        end
    end

    tsct_mul u_sq (.i_clk(i_clk), .i_en(i_en), .i_a(r_x0), .i_b(r_x0), .o_p(y_p));

    t_poly      st     [NST];
    logic [NST-1:0] vld;
    logic [1:0] d_req [LAT];
    t_val       d_x   [LAT];
    logic [LAT-1:0] d_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_v <= '0;
        end else if (i_en) begin
            d_v <= {d_v[LAT-2:0], r_v0};
        end
        if (i_en) begin
            d_req[0] <= r_req0;
            d_x[0]   <= r_x0;
            for (int i = 1; i < LAT; i++) begin
                d_req[i] <= d_req[i-1];
                d_x[i]   <= d_x[i-1];
            end
        end
    end

    assign vld[0]      = d_v[LAT-1];
    assign st[0].req   = d_req[LAT-1];
    assign st[0].x     = d_x[LAT-1];
    assign st[0].y     = y_p;
    assign st[0].acc_s = coef(2 * (SERIES_TERMS - 1) + 1);
    assign st[0].acc_c = coef(2 * (SERIES_TERMS - 1));

    for (genvar g = 0; g < SERIES_TERMS - 1; g++) begin : g_term
        localparam int I = SERIES_TERMS - 2 - g;
        t_val ps, pc;
        t_poly dl [LAT];
        logic [LAT-1:0] dv;
        tsct_mul u_ms (.i_clk(i_clk), .i_en(i_en), .i_a(st[g].y), .i_b(st[g].acc_s),
                       .o_p(ps));
        tsct_mul u_mc (.i_clk(i_clk), .i_en(i_en), .i_a(st[g].y), .i_b(st[g].acc_c),
                       .o_p(pc));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv <= '0;
            end else if (i_en) begin
                dv <= {dv[LAT-2:0], vld[g]};
            end
            if (i_en) begin
                dl[0] <= st[g];
                for (int i = 1; i < LAT; i++) dl[i] <= dl[i-1];
            end
        end
        assign vld[g+1]      = dv[LAT-1];
        assign st[g+1].req   = dl[LAT-1].req;
        assign st[g+1].x     = dl[LAT-1].x;
        assign st[g+1].y     = dl[LAT-1].y;
        assign st[g+1].acc_s = coef(2 * I + 1) + ps;
        assign st[g+1].acc_c = coef(2 * I) + pc;
    end

    localparam int L = SERIES_TERMS - 1;
    t_val sp;
    logic [1:0] f_req [LAT];
    t_val       f_c   [LAT];
    logic [LAT-1:0] f_v;
    tsct_mul u_mx (.i_clk(i_clk), .i_en(i_en), .i_a(st[L].x), .i_b(st[L].acc_s), .o_p(sp));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            f_v <= '0;
        end else if (i_en) begin
            f_v <= {f_v[LAT-2:0], vld[L]};
        end
        if (i_en) begin
            f_req[0] <= st[L].req;
            f_c[0]   <= st[L].acc_c;
            for (int i = 1; i < LAT; i++) begin
                f_req[i] <= f_req[i-1];
                f_c[i]   <= f_c[i-1];
            end
        end
    end
    assign o_valid  = f_v[LAT-1];
    assign o_sc.req = f_req[LAT-1];
    assign o_sc.s   = sp;
    assign o_sc.c   = f_c[LAT-1];

    `include "assert_macros.svh"
    `ASSERT_IMP(a_x_range, i_clk, i_rst_n, r_v0, (r_x0 <= PI_Q40) && (r_x0 >= -PI_Q40))
endmodule
`default_nettype wire

// ===== rtl/tsct_div.sv =====
// pipelined restoring divider for tangent, four quotient bits per stage, then format
`default_nettype none
module tsct_div
    import tsct_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  wire  t_sc   i_sc,
    output logic        o_valid,
    output logic [OUT_W-1:0] o_result,
    output logic [1:0]  o_status
);
    typedef struct packed {
        logic [1:0]        req;
        logic [OUT_W-1:0]  sc_out;
        logic              zero;
        logic              neg;
        logic [127:0]      num;
        logic [VAL_W:0]    d;
        logic [VAL_W+1:0]  rem;
        logic [QUO_W-1:0]  q;
        logic              big;
    } t_dv;

    t_dv       n_in;
    t_dv       st [DIV_STAGES+1];
    logic [DIV_STAGES:0] v;
    logic [VAL_W-1:0] us, uc;
    t_dv       r_s0;
    logic      r_v0;

    always_comb begin
        us = mag(i_sc.s);
        uc = mag(i_sc.c);
        n_in.req    = i_sc.req;
        n_in.sc_out = (i_sc.req == REQ_COS) ? to_q32(i_sc.c) : to_q32(i_sc.s);
        n_in.zero   = (i_sc.c == '0);
        n_in.neg    = i_sc.s[VAL_W-1] ^ i_sc.c[VAL_W-1];
        n_in.num    = ({76'd0, us} << 33) + {76'd0, uc};
        n_in.d      = {uc, 1'b0};
        n_in.rem    = '0;
        n_in.q      = '0;
        n_in.big    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (i_en) r_v0 <= i_valid;
        if (i_en) r_s0 <= n_in;
    end
    assign st[0] = r_s0;
    assign v[0]  = r_v0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        t_dv  n_s;
        t_dv  r_s;
        logic r_vs;
        always_comb begin
            n_s = st[g];
            for (int k = 0; k < DIV_PER_STG; k++) begin
                n_s.rem = {n_s.rem[VAL_W:0], n_s.num[127]};
                n_s.num = n_s.num << 1;
                if (n_s.q[QUO_W-1:QUO_W-2] != 2'b00) n_s.big = 1'b1;
                n_s.q = n_s.q << 1;
                if (n_s.rem >= {1'b0, n_s.d}) begin
                    n_s.rem = n_s.rem - {1'b0, n_s.d};
                    n_s.q[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vs <= 1'b0;
            else if (i_en) r_vs <= v[g];
            if (i_en) r_s <= n_s;
        end
        assign st[g+1] = r_s;
        assign v[g+1]  = r_vs;
    end

    t_dv f;
    logic [QUO_W-1:0] lim;
    logic [OUT_W-1:0] r_res;
    logic [1:0]       r_st;
    logic             r_v;
    assign f   = st[DIV_STAGES];
    assign lim = QUO_W'(OUT_MAX) + QUO_W'(f.neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else if (i_en) r_v <= v[DIV_STAGES];
        if (i_en) begin
            if (f.req != REQ_TAN) begin
                r_res <= f.sc_out;
                r_st  <= ST_OK;
            end else if (f.zero) begin
                r_res <= '0;
                r_st  <= ST_ZERO;
            end else if (f.big || f.q > lim) begin
                r_res <= f.neg ? ~OUT_MAX : OUT_MAX;
                r_st  <= ST_SAT;
            end else begin
                r_res <= f.neg ? OUT_W'(-f.q) : f.q[OUT_W-1:0];
                r_st  <= ST_OK;
            end
        end
    end
    assign o_valid  = r_v;
    assign o_result = r_res;
    assign o_status = r_st;

    `include "assert_macros.svh"
    `ASSERT_IMP(a_st_code, i_clk, i_rst_n, r_v, r_st != 2'd3)
    `ASSERT_IMP(a_zero_res, i_clk, i_rst_n, r_v && (r_st == ST_ZERO), r_res == '0)
endmodule
`default_nettype wire

// ===== rtl/taylor_sine_cosine_tangent.sv =====
// structure: series pipeline (wrap, square, horner terms, final multiply), then divider stages and format
// throughput: one item per cycle; the whole pipeline advances when the output slot is free
// the output register holds one item; a stall on the master side freezes every stage
// reset: synchronous active low, clears all valid bits; data registers are not reset
// no stored tables, so no clearing pass after reset
`default_nettype none
module taylor_sine_cosine_tangent
    import tsct_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // angle
    input  wire  [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // result
    output logic [1:0]  m_axis_tuser   // status
);
    logic en, sv, dv;
    t_sc  sc;

    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    tsct_series u_series (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid), .i_req(s_axis_tuser), .i_angle(s_axis_tdata),
        .o_valid(sv), .o_sc(sc)
    );
    tsct_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sv), .i_sc(sc),
        .o_valid(dv), .o_result(m_axis_tdata), .o_status(m_axis_tuser)
    );
    assign m_axis_tvalid = dv;

    `include "assert_macros.svh"
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire

// ===== verif/taylor_sine_cosine_tangent_tb.sv =====
// testbench for the sine, cosine and tangent block: directed table and random items checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module taylor_sine_cosine_tangent_tb;
    import tsct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int N_RANDOM       = 2000;
    localparam int N_DIRECTED     = 16;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] angle;
        logic        known;
        logic [47:0] result;
        logic [1:0]  status;
    } t_row;

    typedef struct {
        logic [47:0] result;
        logic [1:0]  status;
    } t_trig;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;  // angle
    logic [1:0]  s_axis_tuser;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;  // result
    logic [1:0]  m_axis_tuser;  // status

    t_trig  trig_queue[$];
    int     n_mismatch;
    int     idle_cycles;
    int     sink_wait;
    logic   timed_out;
    logic   stim_done;
    t_row   dir_table[N_DIRECTED];

    taylor_sine_cosine_tangent u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic signed [63:0] q40_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic              neg;
        logic [127:0]      p;
        logic [127:0]      m;
        logic signed [63:0] r;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        m = (p + (128'd1 << 39)) >> 40;
        if (m > 128'h3FFFFFFFFFFFF) m = 128'h3FFFFFFFFFFFF;
        r = 64'(m);
        return neg ? -r : r;
    endfunction

    function automatic logic signed [63:0] series_coef(input int k);
        logic signed [63:0] c;
        case (k)
            0, 1: c = 64'sd1099511627776;
            2:    c = 64'sd549755813888;
            3:    c = 64'sd183251937963;
            4:    c = 64'sd45812984491;
            5:    c = 64'sd9162596898;
            6:    c = 64'sd1527099483;
            7:    c = 64'sd218157069;
            8:    c = 64'sd27269634;
            9:    c = 64'sd3029959;
            10:   c = 64'sd302996;
            11:   c = 64'sd27545;
            12:   c = 64'sd2295;
            13:   c = 64'sd177;
            14:   c = 64'sd13;
            15:   c = 64'sd1;
            default: c = 0;
        endcase
        return ((k / 2) % 2 == 1) ? -c : c;
    endfunction

    function automatic logic signed [63:0] horner(input logic signed [63:0] x, input int odd);
        logic signed [63:0] y;
        logic signed [63:0] acc;
        y = q40_mul(x, x);
        acc = series_coef(2 * (SERIES_TERMS - 1) + odd);
        for (int i = SERIES_TERMS - 2; i >= 0; i--)
            acc = series_coef(2 * i + odd) + q40_mul(y, acc);
        return odd ? q40_mul(x, acc) : acc;
    endfunction

    function automatic logic [47:0] round_q32(input logic signed [63:0] v);
        logic signed [63:0] m;
        m = ((v < 0 ? -v : v) + 128) >>> 8;
        return 48'(v < 0 ? -m : m);
    endfunction

    function automatic t_trig predict_trig(input logic [1:0] req, input logic [31:0] angle);
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic [127:0]       num;
        logic [127:0]       q;
        logic               neg;
        t_trig              t;
        x = 64'(signed'(angle)) * 4096;
        if (x > 64'(PI_Q40)) x = x - 64'(TWO_PI_Q40);
        else if (x < -64'(PI_Q40)) x = x + 64'(TWO_PI_Q40);
        t.status = ST_OK;
        if (req == REQ_COS) begin
            t.result = round_q32(horner(x, 0));
        end else if (req == REQ_TAN) begin
            s = horner(x, 1);
            c = horner(x, 0);
            if (c == 0) begin
                t.result = '0;
                t.status = ST_ZERO;
            end else begin
                neg = (s < 0) != (c < 0);
                num = (128'(s < 0 ? -s : s) << 33) + 128'(c < 0 ? -c : c);
                q = num / (128'(c < 0 ? -c : c) << 1);
                if (q > 128'(OUT_MAX) + (neg ? 1 : 0)) begin
                    t.status = ST_SAT;
                    t.result = neg ? 48'h800000000000 : OUT_MAX;
                end else begin
                    t.result = neg ? 48'(-q) : 48'(q);
                end
            end
        end else begin
            t.result = round_q32(horner(x, 1));
        end
        return t;
    endfunction

    task automatic send_angle(input logic [1:0] req, input logic [31:0] angle);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= angle;
        trig_queue.push_back(predict_trig(req, angle));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_known(input t_row row);
        int last;
        send_angle(row.req, row.angle);
        last = trig_queue.size() - 1;
        if (row.known) begin
            trig_queue[last].result = row.result;
            trig_queue[last].status = row.status;
        end
    endtask

    // sink side waits a random number of cycles for every item
    always @(posedge i_clk) begin
        if (!i_rst_n || (m_axis_tvalid && m_axis_tready)) sink_wait <= $urandom_range(0, 17);
        else if (m_axis_tvalid && sink_wait > 0) sink_wait <= sink_wait - 1;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && (sink_wait == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (trig_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected item %h %h", m_axis_tdata, m_axis_tuser);
            end else begin
                if (m_axis_tdata !== trig_queue[0].result || m_axis_tuser !== trig_queue[0].status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %h/%h got %h/%h", trig_queue[0].result,
                                 trig_queue[0].status, m_axis_tdata, m_axis_tuser);
                end
                void'(trig_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (!stim_done || trig_queue.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end

    initial begin
        wait (timed_out === 1'b1);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [1:0]  req;
        logic [31:0] angle;
        n_mismatch    = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        stim_done     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        dir_table = '{
            '{REQ_SIN, 32'h00000000, 1'b1, 48'h0, ST_OK},
            '{REQ_COS, 32'h00000000, 1'b1, 48'h000100000000, ST_OK},
            '{REQ_TAN, 32'h00000000, 1'b1, 48'h0, ST_OK},
            '{REQ_SIN, 32'h7FFFFFFF, 1'b0, 48'h0, ST_OK},
            '{REQ_COS, 32'h80000000, 1'b0, 48'h0, ST_OK},
            '{REQ_TAN, 32'h7FFFFFFF, 1'b0, 48'h0, ST_OK},
            '{REQ_TAN, 32'h80000000, 1'b0, 48'h0, ST_OK},
            '{REQ_SIN, 32'h3243F6A8, 1'b0, 48'h0, ST_OK},
            '{REQ_COS, 32'hCDBC0958, 1'b0, 48'h0, ST_OK},
            '{REQ_SIN, 32'h3243F6A9, 1'b0, 48'h0, ST_OK},
            '{REQ_TAN, 32'h1921FB54, 1'b0, 48'h0, ST_OK},
            '{REQ_TAN, 32'hE6DE04AC, 1'b0, 48'h0, ST_OK},
            '{REQ_TAN, 32'h1921FB55, 1'b0, 48'h0, ST_OK},
            '{2'd3,    32'h10000000, 1'b0, 48'h0, ST_OK},
            '{2'd3,    32'hFFFFFFFF, 1'b0, 48'h0, ST_OK},
            '{REQ_COS, 32'h00000001, 1'b0, 48'h0, ST_OK}
        };
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_table[i]) send_known(dir_table[i]);
        s_axis_tvalid <= 1'b0;
        // hold off until the pipeline drains
        wait (trig_queue.size() == 0);
        @(negedge i_clk);
        for (int n = 0; n < N_RANDOM; n++) begin
            req = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       angle = $urandom;
                1:       angle = 32'($signed($urandom_range(0, 32'h6487ED51)) - 32'sh3243F6A8);
                2:       angle = 32'h1921FB54 + 32'($signed($urandom_range(0, 64)) - 32);
                default: angle = 32'($signed($urandom_range(0, 32'h1921FB54)));
            endcase
            if (req == 2'd3 && $urandom_range(0, 1)) req = REQ_TAN;
            send_angle(req, angle);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
        wait (trig_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
